FILE: src/mse_pkg.sv
// Shared constants and codes for the MIPS subset execute unit.
package mse_pkg;

    localparam int DMEM_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);

    localparam logic [31:0] START_PC_RESET = 32'h0040_0000;

    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] ST_EXEC    = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_SYSCALL = 3'd2;
    localparam logic [2:0] ST_WRITTEN = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    localparam int IN_W  = 80;
    localparam int OUT_W = 168;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

FILE: src/mse_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module mse_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  mse_pkg::div_req_t req,
    output mse_pkg::div_rsp_t rsp
);

    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;

    always_comb begin
        shifted = {rem_reg[31:0], quo_reg[31]};
        if (shifted >= {1'b0, dvs_reg}) begin
            rem_next = shifted - {1'b0, dvs_reg};
            quo_next = {quo_reg[30:0], 1'b1};
        end else begin
            rem_next = shifted;
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[31:0];

endmodule

FILE: src/mips_subset_execute_unit.sv
// Top level of the MIPS subset execute unit.
// Usage: the s_ channel takes one word per item: execute an instruction at
// the current pc, or write or read one data memory word for the host. The
// m_ channel returns one result word per item: status, next pc, syscall
// register values, read data and the register written.
// cfg_we with cfg_wdata loads the program counter; write it only while idle.
// Path from accept to result: ALU, branch, jump, sw, host writes and unknown
// items finish in S_READ; loads, sb and host reads go on to S_MEM, syscalls
// to S_SYS, multiplies to S_MUL, and divides wait in S_DIV for the divider.
// The next item is accepted in S_IDLE once the result word is loaded, provided
// the receiver takes it, so one item is through before the next enters. Loads
// and the read-modify-write of sb pass through S_MEM because the data memory
// read port is registered; divides are set by the one-bit-per-cycle divider.
// After reset the data memory is swept to zero, all 1024 words, one word per
// cycle, with s_tready low; the register file clears at once through valid
// bits, hi, lo clear and the pc loads 0x00400000.
// A stalled receiver holds the result word; no new item enters until the
// result is taken.
module mips_subset_execute_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [31:0]                cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // action, instruction, mem_word_index, mem_word, zero pad
    input  logic [mse_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status, next_pc, syscall_code, syscall_arg, read_word, dest_register,
    // dest_value
    output logic [mse_pkg::OUT_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MEM, S_SYS, S_MUL, S_DIV
    } state_t;

    typedef enum logic [2:0] {
        K_DONE, K_HRD, K_LW, K_LB, K_SB, K_SYS, K_MUL, K_DIV
    } kind_t;

    localparam int AW = mse_pkg::DMEM_AW;

    state_t       state_reg;
    kind_t        kind_reg, kind;
    logic [AW-1:0] clr_reg;
    logic [31:0]  pc_reg, hi_reg, lo_reg;
    logic [31:0]  rf_valid_reg;
    logic [1:0]   act_reg;
    logic [31:0]  w_reg, hword_reg;
    logic [9:0]   hidx_reg;
    logic [31:0]  b_reg, addr_reg;
    logic [63:0]  prod_reg;
    logic         neg_reg, rneg_reg;

    logic         m_tvalid_reg;
    logic [2:0]   o_status_reg;
    logic [31:0]  o_npc_reg, o_code_reg, o_arg_reg, o_rword_reg, o_dval_reg;
    logic [4:0]   o_dreg_reg;

    logic [31:0]  rf_mem [32];
    logic [31:0]  rf_qa_reg, rf_qb_reg;
    logic [4:0]   ra_reg, rb_reg, ra_addr, rb_addr;
    logic         rf_we;
    logic [4:0]   rf_wa;
    logic [31:0]  rf_wd;

    logic [31:0]  dm_mem [mse_pkg::DMEM_WORDS];
    logic [31:0]  dm_q_reg;
    logic [AW-1:0] dm_raddr, dm_waddr;
    logic         dm_we;
    logic [31:0]  dm_wdata;

    mse_pkg::div_req_t div_req;
    mse_pkg::div_rsp_t div_rsp;

    logic        accept;
    logic [31:0] va, vb, simm, pc4, btarget, addr, hidx_ext, ma, mb;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic        wr, unk, na, nb;
    logic [4:0]  dreg;
    logic [31:0] dval, npc;
    logic [2:0]  status;
    logic [7:0]  lbyte;
    logic [31:0] sb_word;

    logic        fin;
    logic [2:0]  f_status;
    logic [31:0] f_npc, f_code, f_arg, f_rword, f_dval;
    logic [4:0]  f_dreg;
    logic        f_wr;
    logic [63:0] mul_res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);

    assign va = (ra_reg != 5'd0 && rf_valid_reg[ra_reg]) ? rf_qa_reg : 32'd0;
    assign vb = (rb_reg != 5'd0 && rf_valid_reg[rb_reg]) ? rf_qb_reg : 32'd0;

    assign opc = w_reg[31:26];
    assign rs  = w_reg[25:21];
    assign rt  = w_reg[20:16];
    assign rd  = w_reg[15:11];
    assign sh  = w_reg[10:6];
    assign fn  = w_reg[5:0];
    assign simm    = {{16{w_reg[15]}}, w_reg[15:0]};
    assign pc4     = pc_reg + 32'd4;
    assign btarget = pc4 + {simm[29:0], 2'b00};
    assign addr    = va + simm;
    assign hidx_ext = {22'd0, hidx_reg};
    assign na = va[31];
    assign nb = vb[31];

    always_comb begin
        kind   = K_DONE;
        wr     = 1'b0;
        unk    = 1'b0;
        dreg   = rd;
        dval   = 32'd0;
        npc    = pc4;
        status = mse_pkg::ST_EXEC;
        ma     = va;
        mb     = vb;
        priority if (act_reg == mse_pkg::ACT_WRITE) begin
            status = mse_pkg::ST_WRITTEN;
            npc    = pc_reg;
        end else if (act_reg == mse_pkg::ACT_READ) begin
            kind = K_HRD;
        end else if (act_reg != mse_pkg::ACT_EXEC) begin
            unk = 1'b1;
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn[5:1] == 5'h10) begin
            wr = 1'b1; dval = va + vb;
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn[5:1] == 5'h11) begin
            wr = 1'b1; dval = va - vb;
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn == 6'h24) begin
            wr = 1'b1; dval = va & vb;
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn == 6'h25) begin
            wr = 1'b1; dval = va | vb;
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn == 6'h26) begin
            wr = 1'b1; dval = va ^ vb;
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn == 6'h2a) begin
            wr = 1'b1; dval = {31'd0, $signed(va) < $signed(vb)};
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn == 6'h2b) begin
            wr = 1'b1; dval = {31'd0, va < vb};
        end else if (opc == 6'd0 && w_reg[10:6] == 5'd0 && fn == 6'h06) begin
            wr = 1'b1; dval = vb >> va[4:0];
        end else if (opc == 6'd0 && fn == 6'h04) begin
            wr = 1'b1; dval = vb << va[4:0];
        end else if (opc == 6'd0 && fn == 6'h00) begin
            wr = 1'b1; dval = vb << sh;
        end else if (opc == 6'd0 && fn == 6'h02) begin
            wr = 1'b1; dval = vb >> sh;
        end else if (opc == 6'd0 && fn == 6'h03) begin
            wr = 1'b1; dval = $unsigned($signed(vb) >>> sh);
        end else if (opc == 6'd0 && fn == 6'h0c) begin
            kind = K_SYS; status = mse_pkg::ST_SYSCALL;
        end else if (opc == 6'd0 && w_reg[20:0] == 21'h8) begin
            npc = va;
        end else if (w_reg[31:16] == 16'd0 && w_reg[10:0] == 11'h10) begin
            wr = 1'b1; dval = hi_reg;
        end else if (w_reg[31:16] == 16'd0 && w_reg[10:0] == 11'h12) begin
            wr = 1'b1; dval = lo_reg;
        end else if (opc == 6'd0 && w_reg[15:0] == 16'h18) begin
            kind = K_MUL;
            ma = na ? (32'd0 - va) : va;
            mb = nb ? (32'd0 - vb) : vb;
        end else if (opc == 6'd0 && w_reg[15:0] == 16'h19) begin
            kind = K_MUL;
        end else if (opc == 6'd0 && w_reg[15:0] == 16'h1a) begin
            kind = (vb != 32'd0) ? K_DIV : K_DONE;
            ma = na ? (32'd0 - va) : va;
            mb = nb ? (32'd0 - vb) : vb;
        end else if (opc == 6'd0 && w_reg[15:0] == 16'h1b) begin
            kind = (vb != 32'd0) ? K_DIV : K_DONE;
        end else if (opc == 6'h08 || opc == 6'h09) begin
            wr = 1'b1; dreg = rt; dval = va + simm;
        end else if (opc == 6'h0c) begin
            wr = 1'b1; dreg = rt; dval = va & {16'd0, w_reg[15:0]};
        end else if (opc == 6'h0d) begin
            wr = 1'b1; dreg = rt; dval = va | {16'd0, w_reg[15:0]};
        end else if (opc == 6'h0e) begin
            wr = 1'b1; dreg = rt; dval = va ^ {16'd0, w_reg[15:0]};
        end else if (opc == 6'h0a) begin
            wr = 1'b1; dreg = rt; dval = {31'd0, $signed(va) < $signed(simm)};
        end else if (opc == 6'h0b) begin
            wr = 1'b1; dreg = rt; dval = {31'd0, va < simm};
        end else if (opc == 6'h0f) begin
            wr = 1'b1; dreg = rt; dval = {w_reg[15:0], 16'd0};
        end else if (opc == 6'h04) begin
            if (va == vb) npc = btarget;
        end else if (opc == 6'h05) begin
            if (va != vb) npc = btarget;
        end else if (opc == 6'h01 && rt == 5'h01) begin
            if (!na) npc = btarget;
        end else if (opc == 6'h01 && rt == 5'h00) begin
            if (na) npc = btarget;
        end else if (opc == 6'h01 && rt == 5'h11) begin
            if (!na) npc = btarget;
            wr = 1'b1; dreg = 5'd31; dval = pc4;
        end else if (opc == 6'h01 && rt == 5'h10) begin
            if (na) npc = btarget;
            wr = 1'b1; dreg = 5'd31; dval = pc4;
        end else if (opc == 6'h07 && rt == 5'h00) begin
            if (va != 32'd0 && !na) npc = btarget;
        end else if (opc == 6'h06 && rt == 5'h00) begin
            if (va == 32'd0 || na) npc = btarget;
        end else if (opc == 6'h02) begin
            npc = {pc4[31:28], w_reg[25:0], 2'b00};
        end else if (opc == 6'h03) begin
            npc = {pc4[31:28], w_reg[25:0], 2'b00};
            wr = 1'b1; dreg = 5'd31; dval = pc4;
        end else if (opc == 6'h23) begin
            kind = K_LW;
        end else if (opc == 6'h20) begin
            kind = K_LB;
        end else if (opc == 6'h2b) begin
        end else if (opc == 6'h28) begin
            kind = K_SB;
        end else begin
            unk = 1'b1;
        end
        if (unk) begin
            status = mse_pkg::ST_UNKNOWN;
            npc    = pc_reg;
        end
    end

    always_comb begin
        lbyte = dm_q_reg[7:0];
        sb_word = dm_q_reg;
        unique case (addr_reg[1:0])
            2'd0: begin lbyte = dm_q_reg[7:0];   sb_word[7:0]   = b_reg[7:0]; end
            2'd1: begin lbyte = dm_q_reg[15:8];  sb_word[15:8]  = b_reg[7:0]; end
            2'd2: begin lbyte = dm_q_reg[23:16]; sb_word[23:16] = b_reg[7:0]; end
            default: begin lbyte = dm_q_reg[31:24]; sb_word[31:24] = b_reg[7:0]; end
        endcase
    end

    assign mul_res = neg_reg ? (64'd0 - prod_reg) : prod_reg;

    always_comb begin
        fin      = 1'b0;
        f_status = mse_pkg::ST_EXEC;
        f_npc    = pc4;
        f_code   = 32'd0;
        f_arg    = 32'd0;
        f_rword  = 32'd0;
        f_wr     = 1'b0;
        f_dreg   = rt;
        f_dval   = 32'd0;
        dm_we    = 1'b0;
        dm_waddr = addr[AW+1:2];
        dm_wdata = vb;
        dm_raddr = addr[AW+1:2];
        ra_addr  = s_tdata[27:23];
        rb_addr  = s_tdata[22:18];
        div_req.start    = 1'b0;
        div_req.dividend = ma;
        div_req.divisor  = mb;
        unique case (state_reg)
            S_CLEAR: begin
                dm_we    = 1'b1;
                dm_waddr = clr_reg;
                dm_wdata = 32'd0;
            end
            S_READ: begin
                ra_addr = 5'd2;
                rb_addr = 5'd4;
                if (kind == K_HRD) dm_raddr = hidx_ext[AW-1:0];
                if (kind == K_DIV) div_req.start = 1'b1;
                if (act_reg == mse_pkg::ACT_WRITE) begin
                    dm_we    = 1'b1;
                    dm_waddr = hidx_ext[AW-1:0];
                    dm_wdata = hword_reg;
                end else if (act_reg == mse_pkg::ACT_EXEC && opc == 6'h2b) begin
                    dm_we = 1'b1;
                end
                if (kind == K_DONE) begin
                    fin      = 1'b1;
                    f_status = status;
                    f_npc    = npc;
                    f_wr     = wr;
                    f_dreg   = dreg;
                    f_dval   = dval;
                end
            end
            S_MEM: begin
                fin = 1'b1;
                unique case (kind_reg)
                    K_HRD: begin
                        f_status = mse_pkg::ST_READ;
                        f_npc    = pc_reg;
                        f_rword  = dm_q_reg;
                    end
                    K_LW: begin
                        f_wr = 1'b1; f_dval = dm_q_reg;
                    end
                    K_LB: begin
                        f_wr = 1'b1; f_dval = {{24{lbyte[7]}}, lbyte};
                    end
                    default: begin
                        dm_we    = 1'b1;
                        dm_waddr = addr_reg[AW+1:2];
                        dm_wdata = sb_word;
                    end
                endcase
            end
            S_SYS: begin
                fin      = 1'b1;
                f_status = mse_pkg::ST_SYSCALL;
                f_code   = va;
                f_arg    = vb;
            end
            S_MUL: begin
                fin = 1'b1;
            end
            S_DIV: begin
                fin = div_rsp.done;
            end
            default: begin
            end
        endcase
    end

    mse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign rf_we = fin && f_wr && (f_dreg != 5'd0);
    assign rf_wa = f_dreg;
    assign rf_wd = f_dval;

    always_ff @(posedge aclk) begin
        rf_qa_reg <= rf_mem[ra_addr];
        rf_qb_reg <= rf_mem[rb_addr];
        ra_reg    <= ra_addr;
        rb_reg    <= rb_addr;
        if (rf_we) rf_mem[rf_wa] <= rf_wd;
    end

    always_ff @(posedge aclk) begin
        dm_q_reg <= dm_mem[dm_raddr];
        if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            pc_reg       <= mse_pkg::START_PC_RESET;
            hi_reg       <= 32'd0;
            lo_reg       <= 32'd0;
            rf_valid_reg <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(mse_pkg::DMEM_WORDS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        act_reg   <= s_tdata[1:0];
                        w_reg     <= s_tdata[33:2];
                        hidx_reg  <= s_tdata[43:34];
                        hword_reg <= s_tdata[75:44];
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    kind_reg <= kind;
                    b_reg    <= vb;
                    addr_reg <= addr;
                    prod_reg <= ma * mb;
                    neg_reg  <= (fn == 6'h18 || fn == 6'h1a) && (na ^ nb);
                    rneg_reg <= (fn == 6'h1a) && na;
                    unique case (kind)
                        K_HRD, K_LW, K_LB, K_SB: state_reg <= S_MEM;
                        K_SYS:                   state_reg <= S_SYS;
                        K_MUL:                   state_reg <= S_MUL;
                        K_DIV:                   state_reg <= S_DIV;
                        default:                 state_reg <= S_IDLE;
                    endcase
                end
                S_MUL: begin
                    hi_reg    <= mul_res[63:32];
                    lo_reg    <= mul_res[31:0];
                    state_reg <= S_IDLE;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        lo_reg    <= neg_reg ? (32'd0 - div_rsp.quo) : div_rsp.quo;
                        hi_reg    <= rneg_reg ? (32'd0 - div_rsp.rem) : div_rsp.rem;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (fin) begin
                pc_reg       <= f_npc;
                m_tvalid_reg <= 1'b1;
                o_status_reg <= f_status;
                o_npc_reg    <= f_npc;
                o_code_reg   <= f_code;
                o_arg_reg    <= f_arg;
                o_rword_reg  <= f_rword;
                o_dreg_reg   <= rf_we ? f_dreg : 5'd0;
                o_dval_reg   <= rf_we ? f_dval : 32'd0;
                if (rf_we) rf_valid_reg[rf_wa] <= 1'b1;
            end
            if (cfg_we) pc_reg <= cfg_wdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {o_dval_reg, o_dreg_reg, o_rword_reg, o_arg_reg, o_code_reg,
                       o_npc_reg, o_status_reg};

endmodule
